// ===== hw/rtl/sld_pkg.sv =====
// Package for the sync/length packet deframer.
// Holds command and event codes, framing constants and the structs that pass
// between the deframer modules. Depends on nothing.
package sld_pkg;

	// Input commands.
	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_POP     = 2'd2,
		CMD_CONNECT = 2'd3
	} cmd_t;

	// Result event codes.
	typedef enum logic [2:0] {
		EV_BYTE    = 3'd0,
		EV_HEART   = 3'd1,
		EV_PLAY    = 3'd2,
		EV_CACHED  = 3'd3,
		EV_DROP    = 3'd4,
		EV_BAD     = 3'd5,
		EV_TIMEOUT = 3'd6
	} event_t;

	// Framing state, one-hot.
	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_GOT_A = 4'b0010,
		PH_LEN   = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	localparam logic [7:0]  SYNC_A        = 8'hAA;
	localparam logic [7:0]  SYNC_B        = 8'h55;
	localparam logic [7:0]  HB_LEN        = 8'h04;
	localparam logic [7:0]  HB_CODE       = 8'h02;
	localparam logic [7:0]  MAX_SHORT_LEN = 8'd3;
	localparam logic [7:0]  IDX_LEN       = 8'd2;
	localparam logic [7:0]  IDX_THIRD     = 8'd3;
	localparam logic [7:0]  IDX_FOURTH    = 8'd4;
	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
	localparam int          CNT_W         = 5;

	// One accepted input item.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
	} item_t;

	// Link status and link events for the item being processed.
	typedef struct packed {
		logic linked;
		logic connect;
		logic timeout;
	} link_t;

	// Framing outcome for the item being processed.
	typedef struct packed {
		logic        hit;
		event_t      ev;
		logic [7:0]  data;
		logic [7:0]  idx;
		logic        last;
		logic [15:0] ival;
		logic [7:0]  len;
		logic        cache_inc;
	} frame_t;

	// One result item.
	typedef struct packed {
		logic [2:0]       event_res;
		logic [7:0]       data_byte;
		logic [7:0]       byte_index;
		logic             last;
		logic [15:0]      frame_interval;
		logic [7:0]       packet_length;
		logic [CNT_W-1:0] cache_count;
	} result_t;

endpackage

// ===== hw/rtl/sld_if.sv =====
// Valid/ready channel interfaces of the deframer: input items and results.
// Depends on nothing; payload widths follow the item and result fields.
interface sld_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sld_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic        last;
	logic [15:0] frame_interval;
	logic [7:0]  packet_length;
	logic [4:0]  cache_count;

	modport source (output valid, output event_res, output data_byte, output byte_index,
		output last, output frame_interval, output packet_length, output cache_count,
		input ready);
	modport sink (input valid, input event_res, input data_byte, input byte_index,
		input last, input frame_interval, input packet_length, input cache_count,
		output ready);
endinterface

// ===== hw/rtl/sld_link_ctrl.sv =====
// Link control: connection flag, idle millisecond counter and timeout register.
// Depends on sld_pkg.
module sld_link_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            go,
	input  logic [1:0]      cmd,
	output sld_pkg::link_t  link
);
	import sld_pkg::*;

	logic        linked_q;
	logic [15:0] idle_q;
	logic [15:0] timeout_q;
	logic [15:0] idle_inc;

	// Saturating idle count for a tick.
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;

	assign link.linked  = linked_q;
	assign link.connect = go && (cmd_t'(cmd) == CMD_CONNECT) && !linked_q;
	assign link.timeout = go && (cmd_t'(cmd) == CMD_TICK) && linked_q && (idle_inc > timeout_q);

	// Timeout register: the user must write it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Link and idle time update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linked_q <= 1'b0;
			idle_q   <= '0;
		end else if (go) begin
			if (link.connect) begin
				linked_q <= 1'b1;
				idle_q   <= '0;
			end else if (linked_q && (cmd_t'(cmd) == CMD_TICK)) begin
				idle_q <= idle_inc;
				if (link.timeout) begin
					linked_q <= 1'b0;
				end
			end else if (linked_q && (cmd_t'(cmd) == CMD_BYTE)) begin
				idle_q <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/sld_cache_ctr.sv =====
// Cache occupancy counter: counts frames reported as cached, minus pops.
// Depends on sld_pkg.
module sld_cache_ctr #(
	parameter int CACHE_SLOTS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic                    pop,
	input  logic                    inc,
	output logic                    full,
	output logic [sld_pkg::CNT_W-1:0] count
);
	import sld_pkg::*;

	localparam int OCC_W = $clog2(CACHE_SLOTS + 1);

	logic [OCC_W-1:0]       occ_q;
	logic [OCC_W-1:0]       occ_d;
	logic [OCC_W+CNT_W-1:0] occ_ext;

	assign full = (occ_q >= OCC_W'(CACHE_SLOTS));

	// Next occupancy; a pop saturates at zero, a new frame only enters when not full.
	always_comb begin
		occ_d = occ_q;
		if (go) begin
			if (pop && (occ_q != '0)) begin
				occ_d = occ_q - OCC_W'(1);
			end else if (inc && !full) begin
				occ_d = occ_q + OCC_W'(1);
			end
		end
	end

	// The reported count is the occupancy after this step.
	assign occ_ext = {{CNT_W{1'b0}}, occ_d};
	assign count   = occ_ext[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_d;
		end
	end

	// Occupancy never goes past the number of slots.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CACHE_SLOTS))
		else $error("cache occupancy above slot count");

	// Without a processed item the occupancy holds.
	a_occ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(occ_q))
		else $error("cache occupancy changed without an item");

	// Occupancy moves by at most one per item.
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + OCC_W'(1))
			|| (occ_q + OCC_W'(1) == $past(occ_q)))
		else $error("cache occupancy jumped");

endmodule

// ===== hw/rtl/sld_frame_fsm.sv =====
// Framing state machine: sync hunt, length capture, body count and end-of-packet report.
// Depends on sld_pkg.
module sld_frame_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [1:0]       cmd,
	input  logic [7:0]       rx_byte,
	input  sld_pkg::link_t   link,
	input  logic             cache_full,
	output sld_pkg::frame_t  frame
);
	import sld_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  exp_len_q, exp_len_d;
	logic [7:0]  seen_q, seen_d;
	logic [15:0] ival_q, ival_d;
	logic [7:0]  third_q, third_d;
	logic        is_final;

	// The packet ends when the next index would reach the length.
	assign is_final = ({1'b0, seen_q} + 9'd1) == {1'b0, exp_len_q};

	always_comb begin
		phase_d   = phase_q;
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		ival_d    = ival_q;
		third_d   = third_q;
		frame     = '0;
		if (go) begin
			if (link.connect) begin
				phase_d   = PH_HUNT;
				seen_d    = '0;
				exp_len_d = '0;
			end else if (link.timeout) begin
				phase_d = PH_HUNT;
			end else if ((cmd_t'(cmd) == CMD_BYTE) && link.linked) begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == SYNC_A) begin
							phase_d = PH_GOT_A;
						end
					end
					PH_GOT_A: begin
						// A repeated first sync byte stays a candidate start.
						if (rx_byte == SYNC_B) begin
							phase_d = PH_LEN;
						end else if (rx_byte != SYNC_A) begin
							phase_d = PH_HUNT;
						end
					end
					PH_LEN: begin
						exp_len_d  = rx_byte;
						seen_d     = IDX_THIRD;
						frame.hit  = 1'b1;
						frame.data = rx_byte;
						frame.idx  = IDX_LEN;
						frame.len  = rx_byte;
						if (rx_byte <= MAX_SHORT_LEN) begin
							phase_d    = PH_HUNT;
							frame.ev   = EV_BAD;
							frame.last = 1'b1;
						end else begin
							phase_d  = PH_BODY;
							frame.ev = EV_BYTE;
						end
					end
					PH_BODY: begin
						seen_d = seen_q + 8'd1;
						if (seen_q == IDX_THIRD) begin
							third_d = rx_byte;
						end
						if (seen_q == IDX_FOURTH) begin
							ival_d = {third_q, rx_byte};
						end
						frame.hit  = 1'b1;
						frame.data = rx_byte;
						frame.idx  = seen_q;
						frame.len  = exp_len_q;
						frame.ev   = EV_BYTE;
						if (is_final) begin
							phase_d    = PH_HUNT;
							frame.last = 1'b1;
							if (exp_len_q == HB_LEN) begin
								frame.ev = (rx_byte == HB_CODE) ? EV_HEART : EV_BAD;
							end else if (ival_d == '0) begin
								frame.ev = EV_PLAY;
							end else if (!cache_full) begin
								frame.ev        = EV_CACHED;
								frame.ival      = ival_d;
								frame.cache_inc = 1'b1;
							end else begin
								frame.ev   = EV_DROP;
								frame.ival = ival_d;
							end
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
	end

	// Framing state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			exp_len_q <= '0;
			seen_q    <= '0;
			ival_q    <= '0;
			third_q   <= '0;
		end else begin
			phase_q   <= phase_d;
			exp_len_q <= exp_len_d;
			seen_q    <= seen_d;
			ival_q    <= ival_d;
			third_q   <= third_d;
		end
	end

endmodule

// ===== hw/rtl/sync_length_packet_deframer.sv =====
// Top level of the sync/length packet deframer.
// Depends on sld_pkg, sld_if, sld_link_ctrl, sld_cache_ctr and sld_frame_fsm.
//
// Usage:
// The item channel carries commands: a received byte, a millisecond tick, a
// cache pop or a new connection. The result channel returns at most one result
// per item: each packet byte from the length byte on with its index, and on the
// last byte a heartbeat, play now, cached, dropped or malformed report; a
// timeout result when the idle time passes timeout_ms.
// The configuration port writes timeout_ms at any edge with cfg_we high; write
// it only while no transfer is in flight.
// An item is registered in the input register at its transfer, processed from
// there, and its result is held in the output register.
// Throughput is one item per cycle unless the receiver stalls, set by the single
// input register stage; the framing state is updated by one short pass of logic
// per item. Reset clears the link, the framing state, the cache count and the
// valid flags of both pipeline registers, and sets timeout_ms to 5000. When the
// receiver stalls, the held result blocks the processing stage, and the item
// channel drops ready once the input register is occupied as well.
module sync_length_packet_deframer #(
	parameter int CACHE_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	sld_item_if.sink     item,
	sld_result_if.source result
);
	import sld_pkg::*;

	logic    v_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;
	logic    out_free;
	logic    go;
	link_t   link;
	frame_t  frame;
	logic    cache_full;
	logic [CNT_W-1:0] cache_count;

	// The input stage advances whenever the output register can take a result.
	assign out_free   = !out_valid_q || result.ready;
	assign go         = v_s1 && out_free;
	assign item.ready = !v_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.cmd     <= item.cmd;
			item_s1.rx_byte <= item.rx_byte;
		end
	end

	sld_link_ctrl u_link (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.go        (go),
		.cmd       (item_s1.cmd),
		.link      (link)
	);

	sld_frame_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.cmd        (item_s1.cmd),
		.rx_byte    (item_s1.rx_byte),
		.link       (link),
		.cache_full (cache_full),
		.frame      (frame)
	);

	sld_cache_ctr #(
		.CACHE_SLOTS (CACHE_SLOTS)
	) u_cache (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.pop    (cmd_t'(item_s1.cmd) == CMD_POP),
		.inc    (frame.cache_inc),
		.full   (cache_full),
		.count  (cache_count)
	);

	// Result assembly: a timeout report or the framing outcome.
	always_comb begin
		res_d             = '0;
		res_d.cache_count = cache_count;
		if (link.timeout) begin
			res_d.event_res = EV_TIMEOUT;
			res_d.last      = 1'b1;
		end else begin
			res_d.event_res      = frame.ev;
			res_d.data_byte      = frame.data;
			res_d.byte_index     = frame.idx;
			res_d.last           = frame.last;
			res_d.frame_interval = frame.ival;
			res_d.packet_length  = frame.len;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go && (frame.hit || link.timeout);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= res_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.event_res      = res_q.event_res;
	assign result.data_byte      = res_q.data_byte;
	assign result.byte_index     = res_q.byte_index;
	assign result.last           = res_q.last;
	assign result.frame_interval = res_q.frame_interval;
	assign result.packet_length  = res_q.packet_length;
	assign result.cache_count    = res_q.cache_count;

	// A new item never lands on an input register that is not moving on.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && v_s1 |-> out_free)
		else $error("input register overrun");

	// A result that is not the end of a packet is always a plain packet byte.
	a_mid_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.last |-> res_q.event_res == EV_BYTE)
		else $error("non-final result with a report code");

	// A forwarded packet byte lies inside the packet.
	a_byte_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.event_res == EV_BYTE)
			|-> (res_q.byte_index >= IDX_LEN) && (res_q.byte_index < res_q.packet_length))
		else $error("packet byte index outside the packet");

endmodule
